>>> hw/rtl/ilir_pkg.sv
// Shared types, constants and sizes for the indexed word list.
package ilir_pkg;

  // Maximum number of words that the list holds.
  localparam int unsigned CAPACITY = 64;

  // Derived sizes: RAM address, element count and signed compare width.
  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W  = 8;
  localparam int unsigned SW     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

  // Fixed field widths of the transactions.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FIELD_W = 7;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STAT_W  = 2;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_INS_WR,
    S_RM_RD,
    S_SHIFT_DN,
    S_RD_WAIT,
    S_DONE
  } state_e;

  // Input transaction.
  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [POS_W-1:0]  position;
    logic [DATA_W-1:0]        value;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic [FIELD_W-1:0] index_out;
    logic [FIELD_W-1:0] count_out;
    logic [STAT_W-1:0]  status;
  } out_item_t;

endpackage

>>> hw/rtl/ilir_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ilir_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with a registered output.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ilir_ctrl.sv
// Sequencer that decodes each operation and moves list entries through the RAM.
module ilir_ctrl import ilir_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              res_valid_o,
  input  logic              res_take_i,
  output out_item_t         res_o,
  output logic              mem_we_o,
  output logic [ADDR_W-1:0] mem_waddr_o,
  output logic [DATA_W-1:0] mem_wdata_o,
  output logic              mem_re_o,
  output logic [ADDR_W-1:0] mem_raddr_o,
  input  logic [DATA_W-1:0] mem_rdata_i
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   p_q, p_d;
  logic [ADDR_W-1:0]  ptr_q, ptr_d;
  logic [DATA_W-1:0]  val_q, val_d;
  logic [DATA_W-1:0]  data_q, data_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  status_e            st_q, st_d;

  logic               accept;
  logic               full;
  logic signed [SW-1:0] pos_s;
  logic signed [SW-1:0] cnt_s;
  logic signed [SW-1:0] rm_s;
  logic               rm_bad;
  logic               rd_bad;
  logic [CNT_W-1:0]   ins_p;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign full   = (cnt_q == CNT_W'(CAPACITY));

  // Position arithmetic in a signed width that covers position and count.
  always_comb begin
    pos_s  = {{(SW-POS_W){in_item_i.position[POS_W-1]}}, in_item_i.position};
    cnt_s  = $signed({{(SW-CNT_W){1'b0}}, cnt_q});
    rm_s   = (pos_s < 0) ? (pos_s + cnt_s) : pos_s;
    rm_bad = (rm_s < 0) || (rm_s >= cnt_s);
    rd_bad = (pos_s < 0) || (pos_s >= cnt_s);
    if (pos_s < 0) begin
      ins_p = '0;
    end else if (pos_s > cnt_s) begin
      ins_p = cnt_q;
    end else begin
      ins_p = CNT_W'(pos_s);
    end
  end

  // Next state, RAM accesses and result fields.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    ptr_d       = ptr_q;
    val_d       = val_q;
    data_d      = data_q;
    idx_d       = idx_q;
    st_d        = st_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          data_d  = '0;
          idx_d   = '0;
          st_d    = ST_OK;
          state_d = S_DONE;
          case (in_item_i.operation)
            OP_APPEND: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = ADDR_W'(cnt_q);
                mem_wdata_o = in_item_i.value;
                idx_d       = cnt_q;
                cnt_d       = cnt_q + 1'b1;
              end
            end
            OP_INSERT: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                idx_d = ins_p;
                p_d   = ins_p;
                val_d = in_item_i.value;
                cnt_d = cnt_q + 1'b1;
                if (ins_p == cnt_q) begin
                  // Insert at the end needs no shift.
                  mem_we_o    = 1'b1;
                  mem_waddr_o = ADDR_W'(ins_p);
                  mem_wdata_o = in_item_i.value;
                end else begin
                  // Start the upward shift at the last entry.
                  mem_re_o    = 1'b1;
                  mem_raddr_o = ADDR_W'(cnt_q - 1'b1);
                  ptr_d       = ADDR_W'(cnt_q - 1'b1);
                  state_d     = S_SHIFT_UP;
                end
              end
            end
            OP_REMOVE: begin
              if (rm_bad) begin
                st_d = ST_RANGE;
              end else begin
                idx_d       = CNT_W'(rm_s);
                cnt_d       = cnt_q - 1'b1;
                mem_re_o    = 1'b1;
                mem_raddr_o = ADDR_W'(rm_s);
                ptr_d       = ADDR_W'(rm_s);
                state_d     = S_RM_RD;
              end
            end
            OP_READ: begin
              if (rd_bad) begin
                st_d = ST_RANGE;
              end else begin
                idx_d       = CNT_W'(pos_s);
                mem_re_o    = 1'b1;
                mem_raddr_o = ADDR_W'(pos_s);
                state_d     = S_RD_WAIT;
              end
            end
            OP_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
              // Unused codes do nothing.
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        // Entry at ptr moves to ptr + 1; the next lower entry is read meanwhile.
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q + 1'b1;
        mem_wdata_o = mem_rdata_i;
        if (ptr_q == ADDR_W'(p_q)) begin
          state_d = S_INS_WR;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_q - 1'b1;
          ptr_d       = ptr_q - 1'b1;
        end
      end

      S_INS_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ADDR_W'(p_q);
        mem_wdata_o = val_q;
        state_d     = S_DONE;
      end

      S_RM_RD: begin
        // The removed word arrives; cnt_q already holds the new count.
        data_d = mem_rdata_i;
        if (CNT_W'(ptr_q) < cnt_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_q + 1'b1;
          ptr_d       = ptr_q + 1'b1;
          state_d     = S_SHIFT_DN;
        end else begin
          state_d = S_DONE;
        end
      end

      S_SHIFT_DN: begin
        // Entry at ptr moves to ptr - 1; the next higher entry is read meanwhile.
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q - 1'b1;
        mem_wdata_o = mem_rdata_i;
        if (CNT_W'(ptr_q) == cnt_q) begin
          state_d = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_q + 1'b1;
          ptr_d       = ptr_q + 1'b1;
        end
      end

      S_RD_WAIT: begin
        data_d  = mem_rdata_i;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    ptr_q  <= ptr_d;
    val_q  <= val_d;
    data_q <= data_d;
    idx_q  <= idx_d;
    st_q   <= st_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.data_out    = data_q;
  assign res_o.index_out   = FIELD_W'(idx_q);
  assign res_o.count_out   = FIELD_W'(cnt_q);
  assign res_o.status      = st_q;

endmodule

>>> hw/rtl/indexed_list_insert_remove_top.sv
// Indexed word list with append, insert, remove, read and clear operations.
//
// The input channel takes one operation per transaction (operation, position,
// value); the output channel returns exactly one result per transaction with
// the word, its index, the element count after the operation and a status.
// Both channels use valid and stall; a transaction moves when valid is high
// and stall is low. The list lives in one RAM with a registered read port,
// and the sequencer moves at most one entry per cycle through it.
// Append, clear and unused codes finish in the accepting state; read waits
// for the RAM read; insert and remove shift the later entries one at a time
// (an insert at the end shifts none) through the single read and write port
// pair of the RAM. A new operation is taken once the previous result sits
// in the output register, so the next operation overlaps a stalled result.
// Reset empties the list; RAM contents are not cleared and need no pass.
// When the receiver stalls, the result holds in the output register and
// the sequencer holds its next result until the register frees up.
module indexed_list_insert_remove_top import ilir_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic              res_valid;
  logic              res_take;
  out_item_t         res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic              out_valid_q;
  out_item_t         out_item_q;

  // Sequencer.
  ilir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // List storage.
  ilir_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The output register takes a result when it is empty or being drained.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> hw/rtl/ilir_chk.sv
// Port-level checker for the indexed word list, bound to the top level.
module ilir_chk import ilir_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled result stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // The block works on one operation at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second operation taken while busy");

  // A full list reports no word and a count at capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_FULL) |->
      (out_item_o.data_out == '0) && (out_item_o.index_out == '0) &&
      (out_item_o.count_out == FIELD_W'(CAPACITY)))
    else $error("full result malformed");

  // An out-of-range result carries neither word nor index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_RANGE) |->
      (out_item_o.data_out == '0) && (out_item_o.index_out == '0))
    else $error("out-of-range result malformed");

endmodule

bind indexed_list_insert_remove_top ilir_chk u_ilir_chk (.*);
